// ===== hw/rtl/quad_motor_mixer_with_soft_stop_macros.svh =====
// ----------------------------------------------------------------------------
// quad motor mixer assertion macros
// shared concurrent assertion shorthands for the mixer checker
// ----------------------------------------------------------------------------
`ifndef QUAD_MOTOR_MIXER_WITH_SOFT_STOP_MACROS_SVH
`define QUAD_MOTOR_MIXER_WITH_SOFT_STOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define QMM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define QMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/qmm_pkg.sv =====
// ----------------------------------------------------------------------------
// qmm_pkg
// types, constants and codes shared by the quad motor mixer blocks
// ----------------------------------------------------------------------------
package qmm_pkg;

	localparam int THRUST_W   = 14;
	localparam int ATT_W      = 15;
	localparam int LIMIT_W    = 14;
	localparam int SERVO_W    = 12;
	localparam int PULSE_W    = 13;
	localparam int LEVEL_W    = THRUST_W - 2;
	localparam int SUM_W      = 18;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 14;
	localparam int NUM_MOTORS = 4;

	localparam int DECAY_PERCENT = 70;
	localparam int CUTOFF_LEVEL  = 50;
	localparam int MAX_RESULTS   = 16;
	localparam int DECAY_STEPS   = MAX_RESULTS - 1;
	localparam int STEP_W        = $clog2(MAX_RESULTS);

	// level * percent / 100 as one multiply by a scaled reciprocal
	localparam int RECIP_SHIFT  = 26;
	localparam int RECIP_100    = ((1 << RECIP_SHIFT) + 99) / 100;
	localparam int DECAY_MULT   = DECAY_PERCENT * RECIP_100;
	localparam int DECAY_MULT_W = $clog2(DECAY_MULT + 1);
	localparam int PROD_W       = LEVEL_W + DECAY_MULT_W;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [LIMIT_W-1:0] RST_ATTITUDE_LIMIT = LIMIT_W'(500);
	localparam logic [LIMIT_W-1:0] RST_THRUST_LIMIT   = LIMIT_W'(4000);
	localparam logic [SERVO_W-1:0] RST_SERVO_SPAN     = SERVO_W'(1000);
	localparam logic [SERVO_W-1:0] RST_SERVO_BASE     = SERVO_W'(1000);
	localparam logic               RST_DECAY_ENABLE   = 1'b1;

	localparam logic CMD_DRIVE = 1'b0;
	localparam logic CMD_STOP  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ATTITUDE_LIMIT = 3'd0,
		REG_THRUST_LIMIT   = 3'd1,
		REG_SERVO_SPAN     = 3'd2,
		REG_SERVO_BASE     = 3'd3,
		REG_DECAY_ENABLE   = 3'd4
	} qmm_reg_t;

	typedef enum logic [1:0] {
		FAULT_NONE     = 2'd0,
		FAULT_ATTITUDE = 2'd1,
		FAULT_THRUST   = 2'd2,
		FAULT_SERVO    = 2'd3
	} qmm_fault_t;

	typedef enum logic [1:0] {
		JOB_DRIVE = 2'd0,
		JOB_FAULT = 2'd1,
		JOB_STOP  = 2'd2
	} qmm_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_SINGLE = 2'd1,
		ST_DECAY  = 2'd2
	} qmm_state_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] attitude_limit;
		logic [LIMIT_W-1:0] thrust_limit;
		logic [SERVO_W-1:0] servo_span;
		logic [SERVO_W-1:0] servo_base;
		logic               decay_enable;
	} qmm_cfg_t;

	typedef struct packed {
		logic                    cmd;
		logic [THRUST_W-1:0]     thrust;
		logic signed [ATT_W-1:0] roll;
		logic signed [ATT_W-1:0] pitch;
		logic signed [ATT_W-1:0] yaw;
	} qmm_item_t;

	typedef struct packed {
		qmm_kind_t                          kind;
		qmm_fault_t                         fault;
		logic [NUM_MOTORS-1:0][SERVO_W-1:0] mix;
		logic [LEVEL_W-1:0]                 level;
	} qmm_job_t;

	typedef struct packed {
		logic [NUM_MOTORS-1:0][PULSE_W-1:0] pulse;
		qmm_fault_t                         fault;
		logic                               pulses_valid;
		logic                               last;
	} qmm_res_t;

endpackage

// ===== hw/rtl/qmm_req_if.sv =====
// ----------------------------------------------------------------------------
// qmm_req_if
// request channel: command and attitude/thrust demand
// ----------------------------------------------------------------------------
interface qmm_req_if
	import qmm_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic                    cmd;
	logic [THRUST_W-1:0]     thrust;
	logic signed [ATT_W-1:0] roll;
	logic signed [ATT_W-1:0] pitch;
	logic signed [ATT_W-1:0] yaw;

	modport source (output valid, cmd, thrust, roll, pitch, yaw, input ready);
	modport sink   (input valid, cmd, thrust, roll, pitch, yaw, output ready);
endinterface

// ===== hw/rtl/qmm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// qmm_rsp_if
// result channel: four motor pulse widths with fault and framing flags
// ----------------------------------------------------------------------------
interface qmm_rsp_if
	import qmm_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [PULSE_W-1:0] front_left_pulse;
	logic [PULSE_W-1:0] front_right_pulse;
	logic [PULSE_W-1:0] rear_left_pulse;
	logic [PULSE_W-1:0] rear_right_pulse;
	logic [1:0]         fault;
	logic               pulses_valid;
	logic               last;

	modport source (
		output valid, front_left_pulse, front_right_pulse, rear_left_pulse,
			rear_right_pulse, fault, pulses_valid, last,
		input ready
	);
	modport sink (
		input valid, front_left_pulse, front_right_pulse, rear_left_pulse,
			rear_right_pulse, fault, pulses_valid, last,
		output ready
	);
endinterface

// ===== hw/rtl/qmm_cfg_if.sv =====
// ----------------------------------------------------------------------------
// qmm_cfg_if
// register write channel
// ----------------------------------------------------------------------------
interface qmm_cfg_if
	import qmm_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/qmm_fifo.sv =====
// ----------------------------------------------------------------------------
// qmm_fifo
// short job queue between the classifier and the result sequencer
// ----------------------------------------------------------------------------
module qmm_fifo
	import qmm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  qmm_job_t push_job,
	output logic     full,
	input  logic     pop,
	output qmm_job_t pop_job,
	output logic     empty
);

	qmm_job_t            slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;

	assign full    = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign pop_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/qmm_front.sv =====
// ----------------------------------------------------------------------------
// qmm_front
// takes requests, range-checks and mixes them, and queues a job per request
// ----------------------------------------------------------------------------
module qmm_front
	import qmm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	qmm_req_if.sink  req,
	input  qmm_cfg_t cfg,
	input  logic     q_full,
	output logic     q_push,
	output qmm_job_t q_job
);

	qmm_item_t item_q;
	logic      item_valid_q;
	logic      halt_q;

	logic signed [15:0]      lim_s;
	logic signed [15:0]      roll_w, pitch_w, yaw_w;
	logic signed [SUM_W-1:0] t_e, r_e, p_e, y_e;
	logic signed [SUM_W-1:0] sum [NUM_MOTORS];
	logic [NUM_MOTORS-1:0]   mix_ok;
	logic                    att_bad;
	logic                    thr_bad;
	logic                    is_stop;

	assign q_push    = item_valid_q && !q_full;
	assign req.ready = !item_valid_q || q_push;

	always_comb begin
		lim_s   = 16'(cfg.attitude_limit);
		roll_w  = 16'(item_q.roll);
		pitch_w = 16'(item_q.pitch);
		yaw_w   = 16'(item_q.yaw);
		t_e     = SUM_W'(item_q.thrust);
		r_e     = SUM_W'(item_q.roll);
		p_e     = SUM_W'(item_q.pitch);
		y_e     = SUM_W'(item_q.yaw);

		is_stop = halt_q || (item_q.thrust == '0) || (item_q.cmd == CMD_STOP);
		att_bad = (roll_w > lim_s) || (roll_w < -lim_s) ||
			(pitch_w > lim_s) || (pitch_w < -lim_s) ||
			(yaw_w > lim_s) || (yaw_w < -lim_s);
		thr_bad = (item_q.thrust > cfg.thrust_limit);

		// motor order: front left, front right, rear left, rear right
		sum[0] = t_e + r_e + p_e + y_e;
		sum[1] = t_e - r_e + p_e - y_e;
		sum[2] = t_e + r_e - p_e - y_e;
		sum[3] = t_e - r_e - p_e + y_e;

		q_job.kind  = JOB_DRIVE;
		q_job.fault = FAULT_NONE;
		q_job.level = item_q.thrust[THRUST_W-1:2];
		for (int i = 0; i < NUM_MOTORS; i++) begin
			// sums of -1..-3 truncate to zero and pass
			if (sum[i][SUM_W-1]) begin
				mix_ok[i]   = (sum[i] > -18'sd4);
				q_job.mix[i] = '0;
			end else begin
				mix_ok[i]   = (sum[i][SUM_W-2:2] <= (SUM_W-3)'(cfg.servo_span));
				q_job.mix[i] = sum[i][SERVO_W+1:2];
			end
		end

		if (is_stop) begin
			q_job.kind = JOB_STOP;
		end else if (att_bad) begin
			q_job.kind  = JOB_FAULT;
			q_job.fault = FAULT_ATTITUDE;
		end else if (thr_bad) begin
			q_job.kind  = JOB_FAULT;
			q_job.fault = FAULT_THRUST;
		end else if (!(&mix_ok)) begin
			q_job.kind  = JOB_FAULT;
			q_job.fault = FAULT_SERVO;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_q.cmd    <= req.cmd;
			item_q.thrust <= req.thrust;
			item_q.roll   <= req.roll;
			item_q.pitch  <= req.pitch;
			item_q.yaw    <= req.yaw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_q <= 1'b0;
			halt_q       <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				item_valid_q <= 1'b1;
			end else if (q_push) begin
				item_valid_q <= 1'b0;
			end
			if (q_push && (q_job.kind == JOB_FAULT)) begin
				halt_q <= 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/qmm_back.sv =====
// ----------------------------------------------------------------------------
// qmm_back
// pops jobs and emits the single result or the soft stop sequence
// ----------------------------------------------------------------------------
module qmm_back
	import qmm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  qmm_cfg_t  cfg,
	input  logic      q_empty,
	input  qmm_job_t  q_job,
	output logic      q_pop,
	qmm_rsp_if.source rsp
);

	qmm_state_t         state_q, state_d;
	qmm_job_t           job_q;
	logic [LEVEL_W-1:0] level_q, level_d;
	logic [STEP_W-1:0]  step_q, step_d;
	qmm_res_t           res_q, res_d;
	logic               rsp_valid_q;
	logic               out_free;
	logic               emit;
	logic [PROD_W-1:0]  prod;
	logic [LEVEL_W-1:0] scaled;
	logic [LEVEL_W-1:0] next_level;

	assign out_free = !rsp_valid_q || rsp.ready;

	assign rsp.valid             = rsp_valid_q;
	assign rsp.front_left_pulse  = res_q.pulse[0];
	assign rsp.front_right_pulse = res_q.pulse[1];
	assign rsp.rear_left_pulse   = res_q.pulse[2];
	assign rsp.rear_right_pulse  = res_q.pulse[3];
	assign rsp.fault             = res_q.fault;
	assign rsp.pulses_valid      = res_q.pulses_valid;
	assign rsp.last              = res_q.last;

	always_comb begin
		prod   = PROD_W'(level_q) * PROD_W'(DECAY_MULT);
		scaled = prod[RECIP_SHIFT +: LEVEL_W];
		if (!cfg.decay_enable || (scaled <= LEVEL_W'(CUTOFF_LEVEL))) begin
			next_level = '0;
		end else begin
			next_level = scaled;
		end

		state_d = state_q;
		level_d = level_q;
		step_d  = step_q;
		q_pop   = 1'b0;
		emit    = 1'b0;
		res_d   = '0;

		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					level_d = q_job.level;
					step_d  = '0;
					state_d = (q_job.kind == JOB_STOP) ? ST_DECAY : ST_SINGLE;
				end
			end
			ST_SINGLE: begin
				if (out_free) begin
					emit       = 1'b1;
					res_d.last = 1'b1;
					if (job_q.kind == JOB_FAULT) begin
						res_d.fault = job_q.fault;
					end else begin
						res_d.pulses_valid = 1'b1;
						for (int i = 0; i < NUM_MOTORS; i++) begin
							res_d.pulse[i] = PULSE_W'(cfg.servo_base) +
								PULSE_W'(job_q.mix[i]);
						end
					end
					state_d = ST_IDLE;
				end
			end
			ST_DECAY: begin
				if (out_free) begin
					emit               = 1'b1;
					res_d.pulses_valid = 1'b1;
					if ((level_q != '0) && (step_q != STEP_W'(DECAY_STEPS))) begin
						for (int i = 0; i < NUM_MOTORS; i++) begin
							res_d.pulse[i] = PULSE_W'(cfg.servo_base) +
								PULSE_W'(next_level);
						end
						level_d = next_level;
						step_d  = step_q + 1'b1;
					end else begin
						// closing result parks all motors at the base pulse
						for (int i = 0; i < NUM_MOTORS; i++) begin
							res_d.pulse[i] = PULSE_W'(cfg.servo_base);
						end
						res_d.last = 1'b1;
						state_d    = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_job;
		end
		level_q <= level_d;
		step_q  <= step_d;
		if (emit) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/quad_motor_mixer_with_soft_stop.sv =====
// ----------------------------------------------------------------------------
// quad_motor_mixer_with_soft_stop
// x-frame quad motor mixer with latched fault halt and decaying soft stop
// ----------------------------------------------------------------------------
// req carries one command with thrust, roll, pitch and yaw; it is taken when
// req.valid and req.ready are both high. rsp returns the results of each
// request in order, the final one flagged by last; a drive update or a fault
// gives one result, a stop gives up to 15 decay results and a closing one.
// cfg writes a register by index whenever valid is high (ready stays high);
// write only while no request is in flight.
// a taken request passes the input register, the job queue, the job register
// and the result register on its way to rsp. the result sequencer first picks
// up a job, then gives one result per cycle while rsp.ready is high.
// the sequencer sets the rate; a two-entry job queue lets the classifier take
// requests ahead of it.
// a stalled receiver holds the result register; the sequencer then waits and
// the queue and input register back up until req.ready drops.
// reset clears the halt, the queue and the output, and loads the register
// defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module quad_motor_mixer_with_soft_stop
	import qmm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	qmm_req_if.sink   req,
	qmm_rsp_if.source rsp,
	qmm_cfg_if.sink   cfg
);

	qmm_cfg_t cfg_q;
	logic     q_push;
	logic     q_pop;
	logic     q_full;
	logic     q_empty;
	qmm_job_t push_job;
	qmm_job_t pop_job;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attitude_limit <= RST_ATTITUDE_LIMIT;
			cfg_q.thrust_limit   <= RST_THRUST_LIMIT;
			cfg_q.servo_span     <= RST_SERVO_SPAN;
			cfg_q.servo_base     <= RST_SERVO_BASE;
			cfg_q.decay_enable   <= RST_DECAY_ENABLE;
		end else if (cfg.valid && cfg.ready) begin
			case (qmm_reg_t'(cfg.index))
				REG_ATTITUDE_LIMIT: cfg_q.attitude_limit <= cfg.data[LIMIT_W-1:0];
				REG_THRUST_LIMIT:   cfg_q.thrust_limit   <= cfg.data[LIMIT_W-1:0];
				REG_SERVO_SPAN:     cfg_q.servo_span     <= cfg.data[SERVO_W-1:0];
				REG_SERVO_BASE:     cfg_q.servo_base     <= cfg.data[SERVO_W-1:0];
				REG_DECAY_ENABLE:   cfg_q.decay_enable   <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	qmm_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cfg    (cfg_q),
		.q_full (q_full),
		.q_push (q_push),
		.q_job  (push_job)
	);

	qmm_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.pop_job  (pop_job),
		.empty    (q_empty)
	);

	qmm_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_empty (q_empty),
		.q_job   (pop_job),
		.q_pop   (q_pop),
		.rsp     (rsp)
	);

endmodule

// ===== hw/rtl/qmm_checker.sv =====
// ----------------------------------------------------------------------------
// qmm_checker
// port-level checks on the mixer result channel
// ----------------------------------------------------------------------------
`include "quad_motor_mixer_with_soft_stop_macros.svh"

module qmm_checker
	import qmm_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic [PULSE_W-1:0] fl_pulse,
	input logic [PULSE_W-1:0] fr_pulse,
	input logic [PULSE_W-1:0] rl_pulse,
	input logic [PULSE_W-1:0] rr_pulse,
	input logic [1:0]         fault,
	input logic               pulses_valid,
	input logic               last
);

	// a stalled result stays put
	`QMM_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(fl_pulse) && $stable(fault) && $stable(last), "result changed while stalled")

	// pulses are driven exactly when there is no fault
	`QMM_ASSERT_IMPLY(a_valid_vs_fault, clk, arst_n, rsp_valid, pulses_valid == (fault == FAULT_NONE), "pulses_valid disagrees with fault")

	// a fault is a single closing result with zeroed pulses
	`QMM_ASSERT_IMPLY(a_fault_shape, clk, arst_n, rsp_valid && (fault != FAULT_NONE), last && (fl_pulse == '0) && (fr_pulse == '0) && (rl_pulse == '0) && (rr_pulse == '0), "fault result malformed")

	// only soft stop steps are non-final, and they drive all motors alike
	`QMM_ASSERT_IMPLY(a_decay_even, clk, arst_n, rsp_valid && !last, (fault == FAULT_NONE) && (fl_pulse == fr_pulse) && (fl_pulse == rl_pulse) && (fl_pulse == rr_pulse), "uneven decay step")

endmodule

bind quad_motor_mixer_with_soft_stop qmm_checker u_qmm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.fl_pulse     (rsp.front_left_pulse),
	.fr_pulse     (rsp.front_right_pulse),
	.rl_pulse     (rsp.rear_left_pulse),
	.rr_pulse     (rsp.rear_right_pulse),
	.fault        (rsp.fault),
	.pulses_valid (rsp.pulses_valid),
	.last         (rsp.last)
);
